>>> design/alse_pkg.sv
// Shared types and constants for the addressable LED slot encoder.
package alse_pkg;

	// Slot codes driven onto the PWM compare output.
	localparam logic [5:0] DUTY_ONE   = 6'd36;
	localparam logic [5:0] DUTY_ZERO  = 6'd20;
	localparam logic [5:0] DUTY_LATCH = 6'd0;

	// Brightness register reset value (full scale).
	localparam logic [7:0] BRIGHT_RESET = 8'd255;

	// Default number of zero slots in a latch run, and the longest run allowed.
	localparam int LATCH_SLOTS_DEFAULT = 40;
	localparam int MAX_RUN             = 64;

	// Slot counts for the two pixel kinds, minus one as loaded into the counter.
	localparam logic [5:0] RGB_LAST_IDX  = 6'd23;
	localparam logic [5:0] RGBW_LAST_IDX = 6'd31;

	// Register address of brightness_limit.
	localparam logic [0:0] ADDR_BRIGHT = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NORM,
		ST_EMIT
	} alse_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture pixel bytes and form the brightness products
		logic norm;   // divide the products by full scale into the bit shifter
		logic emit;   // write one slot into the output register
		logic last;   // the emitted slot closes the run
		logic latch;  // the current run is a latch run
	} alse_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;  // output register can take a slot this cycle
	} alse_sts_t;

endpackage

>>> design/alse_dp.sv
// Datapath: brightness scaling, bit shifter and output register of the slot encoder.
module alse_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  alse_pkg::alse_cmd_t  cmd,
	output alse_pkg::alse_sts_t  sts,
	input  logic [31:0]          pixel_data,
	input  logic [7:0]           brightness_limit,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [5:0]           out_duty,
	output logic                 out_last
);

	// Exact floor(x / 255) for any x up to 255 * 255, the largest product of two bytes.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		begin
			t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
			div255 = t[15:8];
		end
	endfunction

	logic [15:0] prod_q [4];
	logic [31:0] shift_q;
	logic        out_valid_q;
	logic [5:0]  out_duty_q;
	logic        out_last_q;

	// Products are formed at load; pixel bytes arrive as red, green, blue, white.
	// The shifter holds green, red, blue, white from the top bit down.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			prod_q[0] <= 16'(pixel_data[15:8])  * 16'(brightness_limit);
			prod_q[1] <= 16'(pixel_data[7:0])   * 16'(brightness_limit);
			prod_q[2] <= 16'(pixel_data[23:16]) * 16'(brightness_limit);
			prod_q[3] <= 16'(pixel_data[31:24]) * 16'(brightness_limit);
		end
		if (cmd.norm) begin
			shift_q <= {div255(prod_q[0]), div255(prod_q[1]),
				div255(prod_q[2]), div255(prod_q[3])};
		end else if (cmd.emit) begin
			shift_q <= {shift_q[30:0], 1'b0};
		end
		if (cmd.emit) begin
			if (cmd.latch) begin
				out_duty_q <= alse_pkg::DUTY_LATCH;
			end else if (shift_q[31]) begin
				out_duty_q <= alse_pkg::DUTY_ONE;
			end else begin
				out_duty_q <= alse_pkg::DUTY_ZERO;
			end
			out_last_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_duty     = out_duty_q;
	assign out_last     = out_last_q;

endmodule

>>> design/alse_ctrl.sv
// Controller: sequences load, normalize (pixel items only) and slot emission for each item.
module alse_ctrl #(
	parameter int LATCH_SLOTS = alse_pkg::LATCH_SLOTS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 action,
	input  logic                 has_white,
	input  alse_pkg::alse_sts_t  sts,
	output alse_pkg::alse_cmd_t  cmd
);

	// Latch run length held to the range one to MAX_RUN.
	localparam int LATCH_RUN = (LATCH_SLOTS > alse_pkg::MAX_RUN) ? alse_pkg::MAX_RUN :
		((LATCH_SLOTS < 1) ? 1 : LATCH_SLOTS);
	localparam logic [5:0] LATCH_LAST_IDX = 6'(LATCH_RUN - 1);

	alse_pkg::alse_state_t state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic       latch_q, latch_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= alse_pkg::ST_IDLE;
			cnt_q   <= 6'd0;
			latch_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			latch_q <= latch_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		latch_d   = latch_q;
		in_ready  = 1'b0;
		cmd       = '0;
		cmd.latch = latch_q;
		case (state_q)
			alse_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					latch_d  = action;
					if (action) begin
						cnt_d   = LATCH_LAST_IDX;
						state_d = alse_pkg::ST_EMIT;
					end else begin
						cnt_d   = has_white ? alse_pkg::RGBW_LAST_IDX :
							alse_pkg::RGB_LAST_IDX;
						state_d = alse_pkg::ST_NORM;
					end
				end
			end
			alse_pkg::ST_NORM: begin
				cmd.norm = 1'b1;
				state_d  = alse_pkg::ST_EMIT;
			end
			alse_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = (cnt_q == 6'd0);
					if (cnt_q == 6'd0) begin
						state_d = alse_pkg::ST_IDLE;
					end else begin
						cnt_d = cnt_q - 6'd1;
					end
				end
			end
			default: begin
				state_d = alse_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> design/addressable_led_slot_encoder_top.sv
// Top level of the addressable LED slot encoder: stream and register ports, control and datapath.
// An RGB pixel passes from acceptance through a load step, a divide step and 24 slots, an RGBW
// pixel through load, divide and 32 slots, and a latch item through load and LATCH_RUN slots.
// Slots leave one per cycle while the output side is ready; a stalled output holds them back.
// The next item is accepted only at the edge after the one that registers the last slot, so no
// new item is taken while the current one still has slots to emit.
// Reset is asynchronous and active low: it returns the controller to idle, empties the output
// register and sets brightness_limit to full scale (255).
module addressable_led_slot_encoder_top #(
	parameter int LATCH_SLOTS = alse_pkg::LATCH_SLOTS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input item stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16], white[31:24]
	input  logic [1:0]  s_axis_tuser,   // action[0], has_white[1]
	// Result item stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // duty[5:0], zero fill[7:6]
	output logic        m_axis_tlast,
	// Register port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	alse_pkg::alse_cmd_t cmd;
	alse_pkg::alse_sts_t sts;

	logic [7:0] bright_q;
	logic [5:0] duty;

	// The brightness register is written at the access phase of an APB write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= alse_pkg::BRIGHT_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == alse_pkg::ADDR_BRIGHT)) begin
			bright_q <= pwdata[7:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == alse_pkg::ADDR_BRIGHT) ? {24'd0, bright_q} : 32'd0;

	// The controller decides when to load, normalize and emit; the datapath does the work.
	alse_ctrl #(
		.LATCH_SLOTS (LATCH_SLOTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.action    (s_axis_tuser[0]),
		.has_white (s_axis_tuser[1]),
		.sts       (sts),
		.cmd       (cmd)
	);

	alse_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.pixel_data       (s_axis_tdata),
		.brightness_limit (bright_q),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.out_duty         (duty),
		.out_last         (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, duty};

endmodule
